// ===== hdl/awm_pkg.sv =====
package awm_pkg;

  localparam int DEF_MAX_PATTERN   = 64;
  localparam int DEF_ALPHABET_SIZE = 26;
  localparam int DEF_POSITION_BITS = 16;

  localparam int OPCODE_W  = 2;
  localparam int LETTER_W  = 5;
  localparam int POS_OUT_W = 16;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CLEAR   = 2'd0,
    OP_PATTERN = 2'd1,
    OP_NEWTEXT = 2'd2,
    OP_TEXT    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PINC,
    ST_TREAD,
    ST_DROP_A,
    ST_DROP_B,
    ST_INSERT
  } state_t;

  typedef struct packed {
    op_t                 op;
    logic                letter_ok;
    logic [LETTER_W-1:0] letter;
  } cmd_t;

  typedef struct packed {
    logic                 match_found;
    logic [POS_OUT_W-1:0] match_start;
    logic [POS_OUT_W-1:0] match_end;
    logic                 pattern_overflow;
  } res_t;

endpackage

// ===== hdl/awm_front.sv =====
module awm_front #(
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic [awm_pkg::OPCODE_W-1:0] in_opcode,
  input  logic [awm_pkg::LETTER_W-1:0] in_letter,
  output logic                       cmd_valid,
  output awm_pkg::cmd_t              cmd,
  input  logic                       cmd_pop
);
  import awm_pkg::*;

  cmd_t       q_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       cls;
  logic       wr_en, rd_en;

  // decode and range-check the letter on the way in
  always_comb begin
    cls.op        = op_t'(in_opcode);
    cls.letter_ok = (int'(in_letter) < ALPHABET_SIZE);
    cls.letter    = in_letter;
  end

  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rptr_r];
  assign wr_en     = push && !full;
  assign rd_en     = cmd_pop && cmd_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr_en) wptr_r <= ~wptr_r;
      if (rd_en) rptr_r <= ~rptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) q_r[wptr_r] <= cls;
  end

endmodule

// ===== hdl/awm_resq.sv =====
module awm_resq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          res_push,
  input  awm_pkg::res_t                 res,
  output logic                          res_room,
  output logic                          empty,
  input  logic                          pop,
  output logic                          out_match_found,
  output logic [awm_pkg::POS_OUT_W-1:0] out_match_start,
  output logic [awm_pkg::POS_OUT_W-1:0] out_match_end,
  output logic                          out_pattern_overflow
);
  import awm_pkg::*;

  res_t       q_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_en;
  res_t       head;

  assign empty    = (cnt_r == 2'd0);
  assign res_room = (cnt_r != 2'd2);
  assign rd_en    = pop && !empty;
  assign head     = q_r[rptr_r];

  assign out_match_found      = head.match_found;
  assign out_match_start      = head.match_start;
  assign out_match_end        = head.match_end;
  assign out_pattern_overflow = head.pattern_overflow;

  always_comb begin
    cnt_nxt = cnt_r;
    if (res_push && !rd_en) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (rd_en && !res_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (res_push) wptr_r <= ~wptr_r;
      if (rd_en)    rptr_r <= ~rptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) q_r[wptr_r] <= res;
  end

endmodule

// ===== hdl/awm_back.sv =====
module awm_back #(
  parameter int MAX_PATTERN   = 64,
  parameter int ALPHABET_SIZE = 26,
  parameter int POSITION_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  awm_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          res_room,
  output logic          res_push,
  output awm_pkg::res_t res
);
  import awm_pkg::*;

  localparam int CNT_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int A_W   = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

  // storage
  logic [CNT_W-1:0] tc_mem [ALPHABET_SIZE];
  logic [CNT_W-1:0] wc_mem [ALPHABET_SIZE];
  logic [A_W-1:0]   ring_mem [MAX_PATTERN];
  logic [ALPHABET_SIZE-1:0] tc_vld_r, wc_vld_r;
  logic [CNT_W-1:0] tc_q, wc_q;
  logic [A_W-1:0]   ring_q;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   head_r, head_nxt, tail_r, tail_nxt;
  logic [CNT_W-1:0]   len_r, len_nxt, plen_r, plen_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [A_W-1:0]     let_r, let_nxt, old_r, old_nxt;
  logic [CNT_W-1:0]   t_r, t_nxt, c_r, c_nxt;

  // memory controls
  logic             tc_we, tc_set, tc_clr;
  logic [CNT_W-1:0] tc_wdata;
  logic             wc_we, wc_set, wc_clr;
  logic [A_W-1:0]   wc_waddr, wc_raddr, cmd_let;
  logic [CNT_W-1:0] wc_wdata;
  logic             ring_we;

  logic             ins_en;
  logic [CNT_W-1:0] ins_cnt, t_cur, c_cur;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
    wrap_inc = (idx == IDX_W'(MAX_PATTERN - 1)) ? '0 : idx + 1'b1;
  endfunction

  assign cmd_let = A_W'(cmd.letter);
  assign t_cur   = tc_vld_r[let_r] ? tc_q : '0;
  assign c_cur   = wc_vld_r[let_r] ? wc_q : '0;

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    len_nxt   = len_r;
    plen_nxt  = plen_r;
    pos_nxt   = pos_r;
    let_nxt   = let_r;
    old_nxt   = old_r;
    t_nxt     = t_r;
    c_nxt     = c_r;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    res       = '0;
    tc_we     = 1'b0;
    tc_set    = 1'b0;
    tc_clr    = 1'b0;
    tc_wdata  = (tc_vld_r[let_r] ? tc_q : '0) + 1'b1;
    wc_we     = 1'b0;
    wc_set    = 1'b0;
    wc_clr    = 1'b0;
    wc_waddr  = let_r;
    wc_wdata  = '0;
    wc_raddr  = cmd_let;
    ring_we   = 1'b0;
    ins_en    = 1'b0;
    ins_cnt   = c_r;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid && res_room) begin
          cmd_pop = 1'b1;
          unique case (cmd.op)
            OP_CLEAR: begin
              tc_clr   = 1'b1;
              wc_clr   = 1'b1;
              plen_nxt = '0;
              head_nxt = '0;
              tail_nxt = '0;
              len_nxt  = '0;
              res_push = 1'b1;
            end
            OP_PATTERN: begin
              res_push = 1'b1;
              if (cmd.letter_ok) begin
                if (plen_r == CNT_W'(MAX_PATTERN)) begin
                  res.pattern_overflow = 1'b1;
                end else begin
                  plen_nxt  = plen_r + 1'b1;
                  let_nxt   = cmd_let;
                  state_nxt = ST_PINC;
                end
              end
            end
            OP_NEWTEXT: begin
              wc_clr   = 1'b1;
              head_nxt = '0;
              tail_nxt = '0;
              len_nxt  = '0;
              pos_nxt  = '0;
              res_push = 1'b1;
            end
            OP_TEXT: begin
              if (cmd.letter_ok) begin
                let_nxt   = cmd_let;
                state_nxt = ST_TREAD;
              end else begin
                wc_clr   = 1'b1;
                head_nxt = '0;
                tail_nxt = '0;
                len_nxt  = '0;
                pos_nxt  = pos_r + 1'b1;
                res_push = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_PINC: begin
        tc_we     = 1'b1;
        tc_set    = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_TREAD: begin
        t_nxt = t_cur;
        c_nxt = c_cur;
        if (t_cur == '0) begin
          // letter absent from the pattern empties the window
          wc_clr    = 1'b1;
          head_nxt  = '0;
          tail_nxt  = '0;
          len_nxt   = '0;
          pos_nxt   = pos_r + 1'b1;
          res_push  = 1'b1;
          state_nxt = ST_IDLE;
        end else if (c_cur < t_cur) begin
          ins_en  = 1'b1;
          ins_cnt = c_cur;
        end else begin
          state_nxt = ST_DROP_A;
        end
      end
      ST_DROP_A: begin
        old_nxt   = ring_q;
        wc_raddr  = ring_q;
        head_nxt  = wrap_inc(head_r);
        len_nxt   = len_r - 1'b1;
        if (ring_q == let_r) c_nxt = c_r - 1'b1;
        state_nxt = ST_DROP_B;
      end
      ST_DROP_B: begin
        wc_we     = 1'b1;
        wc_waddr  = old_r;
        wc_wdata  = (wc_vld_r[old_r] ? wc_q : '0) - 1'b1;
        state_nxt = (c_r == t_r) ? ST_DROP_A : ST_INSERT;
      end
      ST_INSERT: begin
        ins_en  = 1'b1;
        ins_cnt = c_r;
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (ins_en) begin
      ring_we   = 1'b1;
      wc_we     = 1'b1;
      wc_set    = 1'b1;
      wc_waddr  = let_r;
      wc_wdata  = ins_cnt + 1'b1;
      pos_nxt   = pos_r + 1'b1;
      res_push  = 1'b1;
      state_nxt = ST_IDLE;
      if (len_r + 1'b1 == plen_r) begin
        res.match_found = 1'b1;
        res.match_start = POS_OUT_W'(pos_r - POSITION_BITS'(len_r));
        res.match_end   = POS_OUT_W'(pos_r);
        wc_clr   = 1'b1;
        head_nxt = '0;
        tail_nxt = '0;
        len_nxt  = '0;
      end else begin
        tail_nxt = wrap_inc(tail_r);
        len_nxt  = len_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      head_r   <= '0;
      tail_r   <= '0;
      len_r    <= '0;
      plen_r   <= '0;
      pos_r    <= '0;
      tc_vld_r <= '0;
      wc_vld_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      len_r   <= len_nxt;
      plen_r  <= plen_nxt;
      pos_r   <= pos_nxt;
      if (tc_clr) begin
        tc_vld_r <= '0;
      end else if (tc_set) begin
        tc_vld_r[let_r] <= 1'b1;
      end
      if (wc_clr) begin
        wc_vld_r <= '0;
      end else if (wc_set) begin
        wc_vld_r[let_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    let_r <= let_nxt;
    old_r <= old_nxt;
    t_r   <= t_nxt;
    c_r   <= c_nxt;
  end

  always_ff @(posedge clk) begin
    if (tc_we) tc_mem[let_r] <= tc_wdata;
    tc_q <= tc_mem[cmd_let];
  end

  always_ff @(posedge clk) begin
    if (wc_we) wc_mem[wc_waddr] <= wc_wdata;
    wc_q <= wc_mem[wc_raddr];
  end

  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[tail_r] <= let_r;
    ring_q <= ring_mem[head_r];
  end

  // window never outgrows the pattern
  a_len_le_plen: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= plen_r)
    else $error("window longer than pattern");

  // a drop only happens when the current letter is still in the window
  a_drop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DROP_A) |-> (len_r != '0 && c_r != '0))
    else $error("drop from an empty window");

  // slot reserved at dispatch is still free when the result lands
  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> res_room)
    else $error("result pushed into a full queue");

  // a command is taken only from the idle state
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> (state_r == ST_IDLE && cmd_valid))
    else $error("command taken while busy");

endmodule

// ===== hdl/anagram_window_matcher_unit.sv =====
// sliding-window anagram search over a stream of letter indexes. each input
// transfer carries an opcode (clear pattern, add pattern letter, start new
// text, text letter) and a letter, and yields exactly one result transfer in
// order. a two-entry command queue on the input side decouples the front
// from the sequencer, and a two-entry result queue decouples the sequencer
// from the consumer, so push is taken while a result still waits for pop.
// control and pattern items are handled from the idle state; a text letter
// outside the alphabet ends in the idle state, one that fits the window or is
// absent from the pattern also passes the count read state, and one that
// pushes older letters out then passes the drop states for every letter that
// leaves the front of the window, since each departure is a read of the
// letter ring and a read-modify-write of the window count memory. all counts
// clear at once through per-letter valid flags, so no clearing pass is
// needed after reset or after a match.
module anagram_window_matcher_unit #(
  parameter int MAX_PATTERN   = awm_pkg::DEF_MAX_PATTERN,
  parameter int ALPHABET_SIZE = awm_pkg::DEF_ALPHABET_SIZE,
  parameter int POSITION_BITS = awm_pkg::DEF_POSITION_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input transfer: push while full is low
  input  logic                          push,
  output logic                          full,
  input  logic [awm_pkg::OPCODE_W-1:0]  in_opcode,
  input  logic [awm_pkg::LETTER_W-1:0]  in_letter,
  // result transfer: pop while empty is low
  output logic                          empty,
  input  logic                          pop,
  output logic                          out_match_found,
  output logic [awm_pkg::POS_OUT_W-1:0] out_match_start,
  output logic [awm_pkg::POS_OUT_W-1:0] out_match_end,
  output logic                          out_pattern_overflow
);
  import awm_pkg::*;

  // front to back command hand-off
  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  // back to result queue hand-off
  logic res_push, res_room;
  res_t res;

  // front: opcode decode, letter range check, command queue
  awm_front #(
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_opcode (in_opcode),
    .in_letter (in_letter),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // back: pattern and window counts, letter ring, window sequencer
  awm_back #(
    .MAX_PATTERN  (MAX_PATTERN),
    .ALPHABET_SIZE(ALPHABET_SIZE),
    .POSITION_BITS(POSITION_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_room  (res_room),
    .res_push  (res_push),
    .res       (res)
  );

  // result queue feeding the output ports
  awm_resq u_resq (
    .clk                  (clk),
    .rst_n                (rst_n),
    .res_push             (res_push),
    .res                  (res),
    .res_room             (res_room),
    .empty                (empty),
    .pop                  (pop),
    .out_match_found      (out_match_found),
    .out_match_start      (out_match_start),
    .out_match_end        (out_match_end),
    .out_pattern_overflow (out_pattern_overflow)
  );

endmodule
